### sv/srtb_pkg.sv
// Shared types and constants for the send-rate token bucket.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package srtb_pkg;

    localparam int RATE_W   = 31;
    localparam int CREDIT_W = 32;
    localparam int ELAPSED_W = 32;
    localparam int BYTES_W  = 16;
    localparam int PROD_W   = RATE_W + ELAPSED_W;
    localparam int ADD_W    = 12;

    localparam logic [RATE_W-1:0]          RATE_RESET   = 31'd8000;
    localparam logic signed [CREDIT_W-1:0] CREDIT_RESET = 32'sd8000;
    localparam logic [RATE_W-1:0]          CAP_MAX      = 31'h7FFF_FFFF;
    localparam logic signed [CREDIT_W-1:0] CREDIT_MIN   = 32'sh8000_0000;

    // floor(x / 1e6) == (x * RECIP_US) >> RECIP_SHIFT, exact for x < 2^31
    localparam logic [31:0] RECIP_US    = 32'd2251799814;
    localparam int          RECIP_SHIFT = 51;

    localparam logic OP_CHECK  = 1'b0;
    localparam logic OP_CHARGE = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [ELAPSED_W-1:0] elapsed_us;
        logic [BYTES_W-1:0]   packet_bytes;
    } in_item_t;

    typedef struct packed {
        logic                       may_send;
        logic signed [CREDIT_W-1:0] quota_now;
    } out_item_t;

    typedef struct packed {
        logic load_in;
        logic step_mul;
        logic step_div;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic is_charge;
    } dp_status_t;

endpackage

`default_nettype wire

### sv/srtb_ctrl.sv
// Sequencer for the token bucket: accept, multiply, divide (checks only), commit.
// Depends on srtb_pkg; drives srtb_datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module srtb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  srtb_pkg::dp_status_t status,
    output srtb_pkg::dp_cmd_t    cmd
);
    import srtb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_UPD  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept, commit;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    // result slot is free, or is emptied this cycle
    assign commit  = (state_reg == ST_UPD) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = status.is_charge ? ST_UPD : ST_DIV;
            end
            ST_DIV: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (commit) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        cmd.load_in  = accept;
        cmd.step_mul = (state_reg == ST_MUL);
        cmd.step_div = (state_reg == ST_DIV);
        cmd.commit   = commit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### sv/srtb_datapath.sv
// Datapath of the token bucket: rate register, credit, refill arithmetic.
// Depends on srtb_pkg; sequenced by srtb_ctrl through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module srtb_datapath #(
    parameter int BURST_SECONDS = 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_write,
    input  logic [srtb_pkg::RATE_W-1:0]  cfg_data,
    input  srtb_pkg::in_item_t           s_data,
    input  srtb_pkg::dp_cmd_t            cmd,
    output srtb_pkg::dp_status_t         status,
    output srtb_pkg::out_item_t          m_data
);
    import srtb_pkg::*;

    localparam int BURST_W = $clog2(BURST_SECONDS + 1);
    localparam int BCAP_W  = RATE_W + BURST_W;
    localparam logic [ELAPSED_W-1:0] FULL_US = ELAPSED_W'(BURST_SECONDS * 1000000);
    localparam logic [BURST_W-1:0]   BURST_K = BURST_W'(BURST_SECONDS);

    logic [RATE_W-1:0]          rate_reg;
    logic signed [CREDIT_W-1:0] credit_reg, credit_next;
    in_item_t                   item_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [RATE_W-1:0]          cap_reg;
    logic                       full_reg;
    logic [ADD_W-1:0]           add_reg;
    out_item_t                  result_reg, result_next;

    logic [BCAP_W-1:0]          burst_cap;
    logic [PROD_W:0]            prod_plus_rate;
    logic [RATE_W+31:0]         recip_prod;
    logic signed [CREDIT_W+1:0] headroom;
    logic signed [CREDIT_W:0]   charged;
    logic signed [CREDIT_W-1:0] refilled;

    assign status.is_charge = (item_reg.operation == OP_CHARGE);
    assign m_data           = result_reg;

    assign burst_cap      = BURST_K * rate_reg;
    assign prod_plus_rate = {1'b0, prod_reg} + {{(PROD_W-RATE_W+1){1'b0}}, rate_reg};
    assign recip_prod     = prod_reg[RATE_W-1:0] * RECIP_US;

    assign headroom = $signed({3'b000, cap_reg})
                    - $signed({{2{credit_reg[CREDIT_W-1]}}, credit_reg});
    assign refilled = credit_reg + $signed({{(CREDIT_W-ADD_W){1'b0}}, add_reg});
    assign charged  = $signed({credit_reg[CREDIT_W-1], credit_reg})
                    - $signed({{(CREDIT_W-BYTES_W+1){1'b0}}, item_reg.packet_bytes});

    always_comb begin
        credit_next = credit_reg;
        if (item_reg.operation == OP_CHARGE) begin
            // saturate at the most negative credit
            if (charged[CREDIT_W] && !charged[CREDIT_W-1]) begin
                credit_next = CREDIT_MIN;
            end else begin
                credit_next = charged[CREDIT_W-1:0];
            end
            result_next.may_send = (credit_next > 0);
        end else if (full_reg
                     || (headroom < $signed({{(CREDIT_W-ADD_W+2){1'b0}}, add_reg}))) begin
            // refill reaches the cap (also when credit sits above a lowered cap)
            credit_next          = $signed({1'b0, cap_reg});
            result_next.may_send = 1'b1;
        end else begin
            credit_next          = refilled;
            result_next.may_send = (refilled > 0);
        end
        result_next.quota_now = credit_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg   <= RATE_RESET;
            credit_reg <= CREDIT_RESET;
        end else begin
            if (cfg_write) rate_reg <= cfg_data;
            if (cmd.commit) credit_reg <= credit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) item_reg <= s_data;
        if (cmd.step_mul) begin
            prod_reg <= rate_reg * item_reg.elapsed_us;
            cap_reg  <= (burst_cap > BCAP_W'(CAP_MAX)) ? CAP_MAX : burst_cap[RATE_W-1:0];
        end
        if (cmd.step_div) begin
            // elapsed >= floor((2^31-1)/rate) <=> rate*(elapsed+1) >= 2^31
            full_reg <= (item_reg.elapsed_us >= FULL_US)
                     || (prod_plus_rate >= (PROD_W+1)'(64'h8000_0000));
            add_reg  <= recip_prod[RECIP_SHIFT +: ADD_W];
        end
        if (cmd.commit) result_reg <= result_next;
    end

endmodule

`default_nettype wire

### sv/send_rate_token_bucket_core.sv
// Top level of the send-rate token bucket: controller plus datapath.
// Depends on srtb_pkg, srtb_ctrl and srtb_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Byte-credit token bucket for outgoing packets. Each input item is either a
// check (operation 0: refill from elapsed_us, then report may_send) or a
// charge (operation 1: subtract packet_bytes, saturating at -2^31). Every
// item yields exactly one result item carrying may_send and the credit left.
// The burst cap is min(BURST_SECONDS * rate_limit, 2^31-1); a refill that
// reaches the cap always reports may_send = 1. A check passes through the steps
// accept, rate x elapsed multiply, reciprocal multiply for the divide by 1e6
// and credit update; a charge skips the divide. One item is in flight at a
// time; the update waits only while an earlier result still sits unaccepted
// in the output register. The next item is accepted from the cycle after the
// update, even if that result is still waiting for m_ready. rate_limit is
// written through the cfg channel, which is always ready; write it only while
// no item is in flight. Reset leaves rate_limit = 8000 and the credit at 8000
// bytes.

module send_rate_token_bucket_core #(
    parameter int BURST_SECONDS = 3
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration: rate_limit in bytes per second
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [srtb_pkg::RATE_W-1:0] cfg_data,
    // input items
    input  logic                        s_valid,
    output logic                        s_ready,
    input  srtb_pkg::in_item_t          s_data,
    // result items
    output logic                        m_valid,
    input  logic                        m_ready,
    output srtb_pkg::out_item_t         m_data
);
    import srtb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    srtb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    srtb_datapath #(
        .BURST_SECONDS (BURST_SECONDS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

### dv/tb_send_rate_token_bucket_core.sv
// Self-checking testbench for send_rate_token_bucket_core: a credit tracker
// predicts every result and checks it. Depends on srtb_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_send_rate_token_bucket_core;
    import srtb_pkg::*;

    localparam int     BURST_SECONDS = 3;
    localparam longint US_PER_SEC    = 1000000;
    localparam longint FULL_WAIT_US  = BURST_SECONDS * US_PER_SEC;
    localparam longint CAP_LIMIT     = 2147483647;
    localparam longint CREDIT_FLOOR  = -64'sd2147483648;
    localparam int     STALL_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int     IDLE_PCT      = 35;
    localparam int     PHASE_ITEMS   = 70;
    localparam int     CALM_CHARGES  = 60;    // max-size charges in the calm stretch

    // Tracks rate and byte credit; holds the expected result of every item
    // accepted and not yet answered.
    class credit_tracker;
        logic [RATE_W-1:0] rate;
        longint            credit;
        out_item_t         pending[$];
        int unsigned       errors;

        function new();
            rate   = RATE_RESET;
            credit = longint'(CREDIT_RESET);
            errors = 0;
        endfunction

        function void set_rate(logic [RATE_W-1:0] value);
            rate = value;
        endfunction

        function void note_item(in_item_t item);
            longint    r;
            longint    cap;
            longint    waited;
            longint    gained;
            longint    sent;
            bit        ok;
            bit        full;
            out_item_t want;
            r   = longint'(rate);
            cap = BURST_SECONDS * r;
            if (cap > CAP_LIMIT)
                cap = CAP_LIMIT;
            if (item.operation == OP_CHECK) begin
                waited = longint'(item.elapsed_us);
                full   = (waited >= FULL_WAIT_US);
                // product would pass 2^31: treat as a full refill
                if (r != 0 && waited >= CAP_LIMIT / r)
                    full = 1'b1;
                if (full) begin
                    credit = cap;
                    ok     = 1'b1;
                end else begin
                    gained = (r * waited) / US_PER_SEC;
                    // also covers credit left above a lowered cap
                    if (cap - credit < gained) begin
                        credit = cap;
                        ok     = 1'b1;
                    end else begin
                        credit = credit + gained;
                        ok     = (credit > 0);
                    end
                end
            end else begin
                sent   = longint'(item.packet_bytes);
                credit = credit - sent;
                if (credit < CREDIT_FLOOR)
                    credit = CREDIT_FLOOR;
                ok = (credit > 0);
            end
            want.may_send  = ok;
            want.quota_now = credit[31:0];
            pending = {pending, want};
        endfunction

        function void complain(string what, longint want, longint got);
            errors++;
            if (errors <= 100)
                $display("%0t ERROR %s: expected %0d, got %0d", $time, what, want, got);
        endfunction

        function void check_item(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 100)
                    $display("%0t ERROR result: expected none, got may_send=%0d quota_now=%0d",
                             $time, got.may_send, got.quota_now);
                return;
            end
            want = pending.pop_front();
            if (got.may_send !== want.may_send)
                complain("may_send", longint'(want.may_send), longint'(got.may_send));
            if (got.quota_now !== want.quota_now)
                complain("quota_now", longint'(want.quota_now), longint'(got.quota_now));
        endfunction
    endclass

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [RATE_W-1:0] cfg_data  = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_item_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_item_t         m_data;

    bit            calm         = 1'b0;  // no idling on either side while set
    int unsigned   quiet_cycles = 0;
    credit_tracker tracker      = new();

    send_rate_token_bucket_core #(
        .BURST_SECONDS (BURST_SECONDS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: back-pressure at random unless in a calm stretch.
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // All handshakes are sampled here, on pre-edge values. Results are
    // checked before the new item is noted; they belong to older items.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                tracker.set_rate(cfg_data);
            if (m_valid && m_ready)
                tracker.check_item(m_data);
            if (s_valid && s_ready)
                tracker.note_item(s_data);
        end
    end

    // Watchdog: any handshake restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("** send_rate_token_bucket_core: FAILED **");
        $finish;
    end

    // Unused payload field is random so the block is seen to ignore it.
    function automatic in_item_t check_of(logic [ELAPSED_W-1:0] waited);
        in_item_t item;
        item.operation    = OP_CHECK;
        item.elapsed_us   = waited;
        item.packet_bytes = BYTES_W'($urandom);
        return item;
    endfunction

    function automatic in_item_t charge_of(logic [BYTES_W-1:0] sent);
        in_item_t item;
        item.operation    = OP_CHARGE;
        item.elapsed_us   = $urandom;
        item.packet_bytes = sent;
        return item;
    endfunction

    // Random item shaped by the current rate: elapsed times mostly inside
    // the partial-refill window or on its edges, charges sized to the cap.
    function automatic in_item_t random_item(logic [RATE_W-1:0] rate);
        longint      r;
        longint      edge_us;
        longint      window;
        longint      chunk;
        longint      pick_us;
        int unsigned pick;
        in_item_t    item;
        r       = longint'(rate);
        edge_us = (r == 0) ? FULL_WAIT_US : CAP_LIMIT / r;
        window  = (edge_us < FULL_WAIT_US) ? edge_us : FULL_WAIT_US;
        chunk   = BURST_SECONDS * r;
        chunk   = (chunk > CAP_LIMIT) ? CAP_LIMIT / 4 + 1 : chunk / 4 + 1;
        if (chunk > 65535)
            chunk = 65535;
        item.elapsed_us   = $urandom;
        item.packet_bytes = BYTES_W'($urandom);
        pick              = $urandom_range(99);
        if ($urandom_range(99) < 55) begin
            item.operation = OP_CHECK;
            if (pick < 40) begin
                item.elapsed_us = $urandom_range(0, int'(window));
            end else if (pick < 55) begin
                pick_us = ($urandom_range(1) && r != 0) ? edge_us : FULL_WAIT_US;
                pick_us = pick_us - 1 + $urandom_range(2);
                item.elapsed_us = pick_us[31:0];
            end else if (pick < 75) begin
                item.elapsed_us = $urandom_range(0, 2000);
            end
        end else begin
            item.operation = OP_CHARGE;
            if (pick < 50)
                item.packet_bytes = BYTES_W'($urandom_range(0, int'(chunk)));
            else if (pick < 60)
                item.packet_bytes = 16'hFFFF;
            else if (pick < 70)
                item.packet_bytes = BYTES_W'($urandom_range(1));
        end
        return item;
    endfunction

    // Called at a clock edge; returns at the edge where the item is taken.
    task automatic send_item(in_item_t item);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drains all outstanding results, then allows for the pipeline latency.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_rate(logic [RATE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [RATE_W-1:0] rates[8];
        rates[0] = RATE_RESET;
        rates[1] = 31'd1;
        rates[2] = CAP_MAX;
        rates[3] = 31'd715827882;   // 3x stays just under 2^31-1
        rates[4] = 31'd715827883;   // 3x clips at 2^31-1
        rates[5] = RATE_W'($urandom_range(1, 100000));
        rates[6] = RATE_W'($urandom_range(100000, 10000000));
        rates[7] = RATE_W'($urandom_range(1, 32'h7FFF_FFFF));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset rate 8000: cap 24000, refill window ends at 268435 us.
        send_item(check_of(32'd0));
        send_item(charge_of(16'hFFFF));
        send_item(charge_of(16'd0));
        send_item(check_of(32'd1));
        send_item(check_of(32'd268434));        // largest partial refill
        send_item(check_of(32'd268435));        // overflow threshold: full
        send_item(charge_of(16'd24000));        // exactly zero: not allowed
        send_item(check_of(32'd124));
        send_item(check_of(32'd125));
        send_item(check_of(32'hFFFF_FFFF));
        send_item(charge_of(16'd8));
        send_item(check_of(32'd1000));          // lands exactly on the cap
        send_item(charge_of(16'd8));
        send_item(check_of(32'd1125));          // would pass the cap: clipped

        // Top rate: any nonzero wait refills completely.
        settle();
        write_rate(CAP_MAX);
        send_item(check_of(32'd0));
        send_item(check_of(32'd1));
        send_item(charge_of(16'hFFFF));

        // Rate 1: credit sits far above the new cap of 3.
        settle();
        write_rate(31'd1);
        send_item(check_of(32'd0));
        send_item(charge_of(16'd3));
        send_item(check_of(32'd999999));
        send_item(check_of(32'd1000000));
        send_item(check_of(32'd2999999));       // just short of the burst window
        send_item(charge_of(16'd3));
        send_item(check_of(32'd3000000));       // burst window: full

        // Zero rate: cap 0, no threshold test, nothing ever added.
        settle();
        write_rate('0);
        send_item(check_of(32'd0));
        send_item(check_of(32'hFFFF_FFFF));
        send_item(charge_of(16'hFFFF));
        send_item(check_of(32'd2999999));

        // Long calm stretch: back-to-back max-size charges, no idling anywhere.
        settle();
        write_rate(31'd1);
        calm <= 1'b1;
        repeat (CALM_CHARGES) send_item(charge_of(16'hFFFF));
        send_item(check_of(32'd999999));
        settle();
        write_rate(CAP_MAX);
        send_item(check_of(32'd0));
        send_item(check_of(32'd1));
        calm <= 1'b0;

        // Random phases over a spread of rates, extremes included.
        foreach (rates[k]) begin
            settle();
            write_rate(rates[k]);
            repeat (PHASE_ITEMS) send_item(random_item(rates[k]));
        end

        settle();
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("** send_rate_token_bucket_core: PASSED **");
        end else begin
            $display("** send_rate_token_bucket_core: FAILED **");
        end
        $finish;
    end

endmodule
